>>> rtl/pfm_pkg.sv
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared codes, widths and constants of the pulse flow meter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfm_pkg;

	// request codes
	localparam logic [1:0] REQ_PULSE   = 2'd0;
	localparam logic [1:0] REQ_SAMPLE  = 2'd1;
	localparam logic [1:0] REQ_RESTORE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PPL       = 2'd0;
	localparam logic [1:0] REG_LPS       = 2'd1;
	localparam logic [1:0] REG_EMA_SHIFT = 2'd2;

	// register reset values
	localparam logic [15:0] PPL_RESET       = 16'd270;
	localparam logic [7:0]  LPS_RESET       = 8'd1;
	localparam logic [2:0]  EMA_SHIFT_RESET = 3'd2;

	// 60e6 * 256 = 234375 * 2^16
	localparam logic [17:0] FLOW_K     = 18'd234375;
	localparam int          FLOW_K_SHL = 16;

	// field widths
	localparam int FLOW_W  = 24;
	localparam int TOTAL_W = 48;
	localparam int STEPS_W = 40;
	localparam int DUE_W   = 16;
	localparam int PCNT_W  = 16;
	localparam int SPS_W   = 24;

	typedef logic [FLOW_W-1:0]  flow_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [STEPS_W-1:0] steps_t;

	localparam flow_t  FLOW_MAX  = '1;
	localparam total_t TOTAL_MAX = '1;
	localparam steps_t STEPS_MAX = '1;

endpackage

`default_nettype wire

>>> rtl/pulse_flow_meter_ema.sv
// ----------------------------------------------------------------------------
// pulse_flow_meter_ema
// Pulse flow meter front end: pulse counting, raw and smoothed flow rate,
// total volume and persisted counter steps.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid/in_ready, req_type,          | input
//           | window_us, restore_steps              |
//   out     | out_valid/out_ready, flow_raw_q8,     | output
//           | flow_ema_q8, pulse_total,             |
//           | liters_total_q8, new_steps            |
//   cfg     | cfg_we, cfg_index, cfg_data           | input
//
// Pulse transactions can arrive back to back.
// A sample runs the 56-step bit-serial liters divider; the step and flow
// dividers run alongside it.
// A restore runs the 24-step serial multiplier.
// Reset is asynchronous; the result register frees the input side, and a
// finished sample waits in its last state while the previous result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_flow_meter_ema (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [23:0] window_us,
	input  wire logic [39:0] restore_steps,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [23:0]      flow_raw_q8,
	output logic [23:0]      flow_ema_q8,
	output logic [47:0]      pulse_total,
	output logic [47:0]      liters_total_q8,
	output logic [15:0]      new_steps,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	localparam int RAW_NW = 34 + pfm_pkg::FLOW_K_SHL;
	localparam int LIT_NW = pfm_pkg::TOTAL_W + 8;

	// configuration
	logic [15:0] ppl_q;
	logic [7:0]  lps_q;
	logic [2:0]  ema_shift_q;

	// block state
	logic [2:0]                    state_q;
	logic                          is_sample_q;
	logic [pfm_pkg::PCNT_W-1:0]    pulses_q;
	pfm_pkg::total_t               total_q;
	pfm_pkg::steps_t               persisted_q;
	pfm_pkg::flow_t                ema_q;
	logic                          seeded_q;

	// per-item operands
	logic [pfm_pkg::PCNT_W-1:0]    p_q;
	logic [23:0]                   elapsed_q;
	logic [15:0]                   eppl_q;
	logic [pfm_pkg::SPS_W-1:0]     sps_q;
	pfm_pkg::steps_t               rsteps_q;
	logic [33:0]                   pk_q;
	logic [39:0]                   den_raw_q;

	// result register
	logic                          out_valid_q;
	pfm_pkg::flow_t                raw_out_q;
	pfm_pkg::flow_t                ema_out_q;
	pfm_pkg::total_t               total_out_q;
	pfm_pkg::total_t               liters_out_q;
	logic [pfm_pkg::DUE_W-1:0]     due_out_q;

	// arithmetic units
	logic                          div_start;
	logic                          mul_start;
	logic                          tgt_busy;
	logic                          raw_busy;
	logic                          lit_busy;
	logic                          mul_busy;
	logic [pfm_pkg::TOTAL_W-1:0]   tgt_quo;
	logic [RAW_NW-1:0]             raw_quo;
	logic [LIT_NW-1:0]             lit_quo;
	logic [63:0]                   mul_prod;

	// handshake and combinational values
	logic                          in_fire;
	logic                          fin_fire;
	logic [15:0]                   eppl;
	logic [7:0]                    elps;
	logic [pfm_pkg::TOTAL_W:0]     total_sum;
	pfm_pkg::steps_t               target;
	pfm_pkg::steps_t               step_diff;
	logic                          step_up;
	logic [pfm_pkg::DUE_W-1:0]     due;
	pfm_pkg::flow_t                raw;
	logic [31:0]                   ema_ext;
	logic [31:0]                   ema_acc;
	logic [31:0]                   ema_rnd;
	pfm_pkg::flow_t                ema_next;
	pfm_pkg::total_t               liters;
	pfm_pkg::total_t               restore_total;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign fin_fire = (state_q == ST_FIN) && (!is_sample_q || !out_valid_q || out_ready);

	// zero register values count as one
	assign eppl = (ppl_q == '0) ? 16'd1 : ppl_q;
	assign elps = (lps_q == '0) ? 8'd1 : lps_q;

	assign total_sum = {1'b0, total_q}
		+ {{(pfm_pkg::TOTAL_W + 1 - pfm_pkg::PCNT_W){1'b0}}, pulses_q};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppl_q       <= pfm_pkg::PPL_RESET;
			lps_q       <= pfm_pkg::LPS_RESET;
			ema_shift_q <= pfm_pkg::EMA_SHIFT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pfm_pkg::REG_PPL:       ppl_q       <= cfg_data;
				pfm_pkg::REG_LPS:       lps_q       <= cfg_data[7:0];
				pfm_pkg::REG_EMA_SHIFT: ema_shift_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			is_sample_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (req_type == pfm_pkg::REQ_SAMPLE)) begin
						state_q     <= ST_PREP;
						is_sample_q <= 1'b1;
					end else if (in_fire && (req_type == pfm_pkg::REQ_RESTORE)) begin
						state_q     <= ST_PREP;
						is_sample_q <= 1'b0;
					end
				end
				ST_PREP:  state_q <= ST_START;
				ST_START: state_q <= ST_RUN;
				ST_RUN: begin
					if (!tgt_busy && !raw_busy && !lit_busy && !mul_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand capture and constant products
	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_q       <= pulses_q;
			elapsed_q <= window_us;
			eppl_q    <= eppl;
			sps_q     <= {8'd0, eppl} * {16'd0, elps};
			rsteps_q  <= restore_steps;
		end
		if (state_q == ST_PREP) begin
			pk_q      <= p_q * pfm_pkg::FLOW_K;
			den_raw_q <= elapsed_q * eppl_q;
		end
	end

	assign div_start = (state_q == ST_START) && is_sample_q;
	assign mul_start = (state_q == ST_START) && !is_sample_q;

	// total pulses / pulses per step
	pfm_div #(.NW(pfm_pkg::TOTAL_W), .DW(pfm_pkg::SPS_W)) u_div_tgt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (total_q),
		.den    (sps_q),
		.busy   (tgt_busy),
		.quo    (tgt_quo)
	);

	// pulses * 60e6 * 256 / (elapsed * pulses per liter)
	pfm_div #(.NW(RAW_NW), .DW(40)) u_div_raw (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({pk_q, {pfm_pkg::FLOW_K_SHL{1'b0}}}),
		.den    (den_raw_q),
		.busy   (raw_busy),
		.quo    (raw_quo)
	);

	// total pulses * 256 / pulses per liter
	pfm_div #(.NW(LIT_NW), .DW(16)) u_div_lit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({total_q, 8'd0}),
		.den    (eppl_q),
		.busy   (lit_busy),
		.quo    (lit_quo)
	);

	// restored steps * pulses per step
	pfm_mul #(.AW(pfm_pkg::STEPS_W), .BW(pfm_pkg::SPS_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (rsteps_q),
		.b      (sps_q),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	// saturate unit results
	always_comb begin
		target    = (tgt_quo[47:40] != '0) ? pfm_pkg::STEPS_MAX : tgt_quo[39:0];
		step_up   = (target > persisted_q);
		step_diff = target - persisted_q;
		if (!step_up) begin
			due = '0;
		end else if (step_diff[39:16] != '0) begin
			due = '1;
		end else begin
			due = step_diff[15:0];
		end

		if (elapsed_q == '0) begin
			raw = '0;
		end else if (raw_quo[RAW_NW-1:24] != '0) begin
			raw = pfm_pkg::FLOW_MAX;
		end else begin
			raw = raw_quo[23:0];
		end

		liters        = (lit_quo[55:48] != '0) ? pfm_pkg::TOTAL_MAX : lit_quo[47:0];
		restore_total = (mul_prod[63:48] != '0) ? pfm_pkg::TOTAL_MAX : mul_prod[47:0];
	end

	// ema: (ema * (2^s - 1) + raw + round) >> s
	always_comb begin
		ema_ext = {8'd0, ema_q};
		ema_rnd = (32'd1 << ema_shift_q) >> 1;
		ema_acc = (ema_ext << ema_shift_q) - ema_ext + {8'd0, raw} + ema_rnd;
		ema_next = raw;
		if (seeded_q) begin
			ema_next = 24'((ema_acc >> ema_shift_q) & 32'h00FF_FFFF);
		end
	end

	// meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulses_q    <= '0;
			total_q     <= '0;
			persisted_q <= '0;
			ema_q       <= '0;
			seeded_q    <= 1'b0;
		end else begin
			if (in_fire && (req_type == pfm_pkg::REQ_PULSE) && (pulses_q != '1)) begin
				pulses_q <= pulses_q + 1'b1;
			end
			if (in_fire && (req_type == pfm_pkg::REQ_SAMPLE)) begin
				pulses_q <= '0;
				total_q  <= total_sum[pfm_pkg::TOTAL_W] ? pfm_pkg::TOTAL_MAX
				                                        : total_sum[pfm_pkg::TOTAL_W-1:0];
			end
			if (fin_fire && is_sample_q) begin
				if (step_up) begin
					persisted_q <= target;
				end
				ema_q    <= ema_next;
				seeded_q <= 1'b1;
			end
			if (fin_fire && !is_sample_q) begin
				persisted_q <= rsteps_q;
				total_q     <= restore_total;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire && is_sample_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire && is_sample_q) begin
			raw_out_q    <= raw;
			ema_out_q    <= ema_next;
			total_out_q  <= total_q;
			liters_out_q <= liters;
			due_out_q    <= due;
		end
	end

	assign out_valid       = out_valid_q;
	assign flow_raw_q8     = raw_out_q;
	assign flow_ema_q8     = ema_out_q;
	assign pulse_total     = total_out_q;
	assign liters_total_q8 = liters_out_q;
	assign new_steps       = due_out_q;

	// a sample or restore transaction closes the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && ((req_type == pfm_pkg::REQ_SAMPLE) || (req_type == pfm_pkg::REQ_RESTORE))
		|=> !in_ready)
	else $error("input side still open after a sample or restore transaction");

	// a counted pulse always leaves a nonzero window count
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (req_type == pfm_pkg::REQ_PULSE) |=> (pulses_q != '0))
	else $error("pulse transaction not counted");

	// a divider or the multiplier is running after a start
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START) |=> (tgt_busy || mul_busy))
	else $error("no unit running after start");

	// a result appears only from the final state of a sample
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN) && $past(is_sample_q))
	else $error("result raised outside a finished sample");

endmodule

`default_nettype wire

>>> rtl/pfm_div.sv
// ----------------------------------------------------------------------------
// pfm_div
// Bit-serial restoring divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module pfm_div #(
	parameter int NW = 48,
	parameter int DW = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic [NW-1:0]      quo
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] acc_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          qbit;

	// one trial subtract per step
	always_comb begin
		trial = {rem_q, acc_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = ~diff[DW];
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// numerator shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[NW-2:0], qbit};
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = acc_q;

endmodule

`default_nettype wire

>>> rtl/pfm_mul.sv
// ----------------------------------------------------------------------------
// pfm_mul
// Bit-serial shift-add multiplier, one multiplier bit per clock, msb first.
// ----------------------------------------------------------------------------
`default_nettype none

module pfm_mul #(
	parameter int AW = 40,
	parameter int BW = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic                  busy,
	output logic [AW+BW-1:0]      prod
);

	localparam int CW = $clog2(BW + 1);

	logic [AW+BW-1:0] acc_q;
	logic [AW-1:0]    a_q;
	logic [BW-1:0]    b_q;
	logic [CW-1:0]    cnt_q;
	logic [AW+BW-1:0] addend;

	// partial product for the current bit
	assign addend = b_q[BW-1] ? {{BW{1'b0}}, a_q} : '0;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(BW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[AW+BW-2:0], 1'b0} + addend;
			b_q   <= {b_q[BW-2:0], 1'b0};
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = acc_q;

endmodule

`default_nettype wire

>>> dv/pulse_flow_meter_ema_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_flow_meter_ema_tb
// Self-checking bench for the pulse flow meter. A queue of requests feeds a
// clocked driver; a clocked monitor predicts each reading at input
// acceptance and compares every output transaction field by field. Both
// sides idle at random, and the output side twice holds off long enough to
// back the block up. Runs through several register settings and extremes.
// ----------------------------------------------------------------------------

module pulse_flow_meter_ema_tb;

	localparam logic [1:0]  REQ_UNUSED    = 2'd3;
	localparam logic [63:0] MAX16         = 64'hFFFF;
	localparam logic [63:0] MAX24         = 64'hFF_FFFF;
	localparam logic [63:0] MAX40         = 64'hFF_FFFF_FFFF;
	localparam logic [63:0] MAX48         = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] US_PER_MIN_Q8 = 64'd15_360_000_000;
	localparam int          IDLE_GAP      = 80;
	localparam int          HOLD_CYCLES   = 600;
	localparam int          CYCLE_LIMIT   = 1_200_000;
	localparam int          PHASES        = 8;
	localparam int          PHASE_ITEMS   = 150;

	typedef struct packed {
		logic [1:0]  req;
		logic [23:0] elapsed;
		logic [39:0] rsteps;
	} meter_req_t;

	typedef struct packed {
		pfm_pkg::flow_t  raw;
		pfm_pkg::flow_t  ema;
		pfm_pkg::total_t total;
		pfm_pkg::total_t liters;
		logic [15:0]     due;
	} meter_reading_t;

	// dut signals
	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type        = pfm_pkg::REQ_PULSE;
	logic [23:0] window_us       = '0;
	logic [39:0] restore_steps   = '0;
	logic        out_valid;
	logic        out_ready       = 1'b0;
	logic [23:0] flow_raw_q8;
	logic [23:0] flow_ema_q8;
	logic [47:0] pulse_total;
	logic [47:0] liters_total_q8;
	logic [15:0] new_steps;
	logic        cfg_we          = 1'b0;
	logic [1:0]  cfg_index       = pfm_pkg::REG_PPL;
	logic [15:0] cfg_data        = '0;

	// register shadow
	logic [15:0] ppl_reg   = pfm_pkg::PPL_RESET;
	logic [7:0]  lps_reg   = pfm_pkg::LPS_RESET;
	logic [2:0]  shift_reg = pfm_pkg::EMA_SHIFT_RESET;

	// meter state as predicted
	logic [15:0]     win_pulses  = '0;
	pfm_pkg::total_t pulses_acc  = '0;
	pfm_pkg::steps_t steps_done  = '0;
	pfm_pkg::flow_t  ema_q8      = '0;
	logic            ema_seeded  = 1'b0;

	meter_req_t     pending_requests[$];
	meter_reading_t expected_readings[$];

	// handshake bookkeeping between the edge processes
	logic in_accepted  = 1'b0;
	logic out_accepted = 1'b0;
	logic in_calm      = 1'b0;
	logic out_calm     = 1'b0;
	int unsigned in_gap    = 0;
	int unsigned out_stall = 0;
	int unsigned hold_left = 0;

	int unsigned mismatches       = 0;
	int unsigned readings_checked = 0;
	int unsigned n_pulses         = 0;
	int unsigned n_samples        = 0;
	int unsigned n_restores       = 0;
	int unsigned n_unused         = 0;
	int unsigned n_settings       = 1;
	int unsigned cycles           = 0;

	pulse_flow_meter_ema u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.window_us       (window_us),
		.restore_steps   (restore_steps),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.flow_raw_q8     (flow_raw_q8),
		.flow_ema_q8     (flow_ema_q8),
		.pulse_total     (pulse_total),
		.liters_total_q8 (liters_total_q8),
		.new_steps       (new_steps),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [23:0] rand24();
		return 24'($urandom);
	endfunction

	function automatic logic [39:0] rand40();
		return {8'($urandom), $urandom};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	task automatic check_field(input string fname, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("reading %0d: %s is %0d, expected %0d",
				readings_checked, fname, got, want));
	endtask

	// advance the meter state for one accepted transaction
	task automatic meter_predict(input meter_req_t r);
		logic [63:0] ppl_e, per_step, p, tot, tgt, due, raw, liters, acc, rnd, e64, rs;
		meter_reading_t rd;
		ppl_e    = (ppl_reg == '0) ? 64'd1 : {48'd0, ppl_reg};
		per_step = ppl_e * ((lps_reg == '0) ? 64'd1 : {56'd0, lps_reg});
		case (r.req)
			pfm_pkg::REQ_PULSE: begin
				n_pulses++;
				if (win_pulses != 16'hFFFF)
					win_pulses = win_pulses + 16'd1;
			end
			pfm_pkg::REQ_RESTORE: begin
				n_restores++;
				rs = {24'd0, r.rsteps};
				steps_done = r.rsteps;
				if (rs > MAX48 / per_step)
					pulses_acc = pfm_pkg::TOTAL_MAX;
				else begin
					acc = rs * per_step;
					pulses_acc = acc[47:0];
				end
			end
			pfm_pkg::REQ_SAMPLE: begin
				n_samples++;
				p = {48'd0, win_pulses};
				win_pulses = '0;
				tot = {16'd0, pulses_acc} + p;
				if (tot > MAX48)
					tot = MAX48;
				pulses_acc = tot[47:0];

				// persisted counter steps newly due
				tgt = tot / per_step;
				if (tgt > MAX40)
					tgt = MAX40;
				due = 64'd0;
				if (tgt > {24'd0, steps_done}) begin
					due = tgt - {24'd0, steps_done};
					steps_done = tgt[39:0];
				end
				if (due > MAX16)
					due = MAX16;

				// instantaneous flow, zero on an empty interval
				raw = 64'd0;
				if (r.elapsed != '0) begin
					raw = (p * US_PER_MIN_Q8) / ({40'd0, r.elapsed} * ppl_e);
					if (raw > MAX24)
						raw = MAX24;
				end

				// smoothing, first sample seeds the average
				if (!ema_seeded) begin
					ema_q8 = raw[23:0];
					ema_seeded = 1'b1;
				end else begin
					e64 = {40'd0, ema_q8};
					rnd = (shift_reg == 3'd0) ? 64'd0 : (64'd1 << (shift_reg - 3'd1));
					acc = (e64 * ((64'd1 << shift_reg) - 64'd1) + raw + rnd) >> shift_reg;
					if (acc > MAX24)
						acc = MAX24;
					ema_q8 = acc[23:0];
				end

				liters = (tot << 8) / ppl_e;
				if (liters > MAX48)
					liters = MAX48;

				rd.raw    = raw[23:0];
				rd.ema    = ema_q8;
				rd.total  = tot[47:0];
				rd.liters = liters[47:0];
				rd.due    = due[15:0];
				expected_readings.push_back(rd);
			end
			default: n_unused++;
		endcase
	endtask

	// input and output monitor
	always @(posedge clk) begin : watch
		meter_req_t     acc_req;
		meter_reading_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				acc_req.req     = req_type;
				acc_req.elapsed = window_us;
				acc_req.rsteps  = restore_steps;
				meter_predict(acc_req);
				in_accepted = 1'b1;
			end
			if (out_valid && out_ready) begin
				out_accepted = 1'b1;
				if (expected_readings.size() == 0)
					report_mismatch($sformatf("reading %0d arrived with none expected",
						readings_checked));
				else begin
					want = expected_readings.pop_front();
					check_field("flow_raw_q8", {40'd0, flow_raw_q8}, {40'd0, want.raw});
					check_field("flow_ema_q8", {40'd0, flow_ema_q8}, {40'd0, want.ema});
					check_field("pulse_total", {16'd0, pulse_total}, {16'd0, want.total});
					check_field("liters_total_q8", {16'd0, liters_total_q8},
						{16'd0, want.liters});
					check_field("new_steps", {48'd0, new_steps}, {48'd0, want.due});
				end
				readings_checked++;
			end
		end
	end

	// request driver
	always @(negedge clk) begin : drive_in
		logic       nv;
		meter_req_t nx;
		if (arst_n) begin
			nv = in_valid;
			if (in_accepted) begin
				nv = 1'b0;
				in_accepted = 1'b0;
			end
			if (!nv) begin
				if (in_gap != 0)
					in_gap--;
				else if (pending_requests.size() != 0) begin
					nx = pending_requests.pop_front();
					req_type      <= nx.req;
					window_us     <= nx.elapsed;
					restore_steps <= nx.rsteps;
					nv = 1'b1;
					in_gap = in_calm ? 0 : $urandom_range(0, 18);
				end
			end
			in_valid <= nv;
		end
	end

	// reading receiver, with long hold-offs to back the block up
	always @(negedge clk) begin : drive_out
		if (arst_n) begin
			if (out_accepted) begin
				out_accepted = 1'b0;
				out_stall = out_calm ? 0 : $urandom_range(0, 18);
				if (readings_checked == 20 || readings_checked == 150)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_stall != 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] req, input logic [23:0] el,
			input logic [39:0] rs);
		meter_req_t r;
		r.req     = req;
		r.elapsed = el;
		r.rsteps  = rs;
		pending_requests.push_back(r);
	endtask

	// one measurement window: a run of pulses closed by a sample
	task automatic queue_window(input int unsigned n, input logic [23:0] el);
		repeat (n)
			push_item(pfm_pkg::REQ_PULSE, rand24(), rand40());
		push_item(pfm_pkg::REQ_SAMPLE, el, rand40());
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || in_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			pfm_pkg::REG_PPL:       ppl_reg = data;
			pfm_pkg::REG_LPS:       lps_reg = data[7:0];
			pfm_pkg::REG_EMA_SHIFT: shift_reg = data[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin : stimulus
		int unsigned ph, budget, npl, pick;
		logic [23:0] el;
		logic [15:0] ppl_v;
		logic [7:0]  lps_v;
		logic [2:0]  sh_v;

		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, field extremes and corner cases
		queue_window(3, 24'd1000);
		queue_window(1, 24'd0);
		queue_window(2, 24'hFF_FFFF);
		queue_window(5, 24'd1);
		push_item(REQ_UNUSED, 24'hFF_FFFF, 40'hFF_FFFF_FFFF);
		push_item(pfm_pkg::REQ_RESTORE, 24'd0, 40'd0);
		queue_window(0, 24'd500);
		push_item(pfm_pkg::REQ_RESTORE, 24'hFF_FFFF, 40'hFF_FFFF_FFFF);
		queue_window(2, 24'd200000);
		push_item(pfm_pkg::REQ_RESTORE, rand24(), 40'd5);
		queue_window(1, 24'd100);
		wait_idle();

		// random windows under a range of register settings
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin ppl_v = 16'd1;     lps_v = 8'd1;   sh_v = 3'd0; end
				1: begin ppl_v = 16'hFFFF;  lps_v = 8'hFF;  sh_v = 3'd7; end
				2: begin ppl_v = 16'd0;     lps_v = 8'd0;   sh_v = 3'd1; end
				3: begin
					ppl_v = pfm_pkg::PPL_RESET;
					lps_v = pfm_pkg::LPS_RESET;
					sh_v  = pfm_pkg::EMA_SHIFT_RESET;
				end
				4: begin
					ppl_v = 16'($urandom_range(1, 50));
					lps_v = 8'($urandom);
					sh_v  = 3'($urandom);
				end
				5: begin ppl_v = 16'($urandom); lps_v = 8'hFF; sh_v = 3'd7; end
				default: begin
					ppl_v = 16'($urandom);
					lps_v = 8'($urandom);
					sh_v  = 3'($urandom);
				end
			endcase
			write_reg(pfm_pkg::REG_PPL, ppl_v);
			write_reg(pfm_pkg::REG_LPS, {8'($urandom), lps_v});
			write_reg(pfm_pkg::REG_EMA_SHIFT, {13'($urandom), sh_v});
			n_settings++;
			in_calm  = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);

			budget = 0;
			while (budget < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 84) begin
					npl = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 120)
						: $urandom_range(0, 15);
					case ($urandom_range(0, 9))
						0:          el = 24'd0;
						1, 2, 3, 4: el = 24'($urandom_range(1, 2000));
						5, 6, 7:    el = 24'($urandom_range(2001, 300000));
						default:    el = rand24();
					endcase
					queue_window(npl, el);
					budget += npl + 1;
				end else if (pick < 94) begin
					push_item(pfm_pkg::REQ_RESTORE, rand24(),
						$urandom_range(0, 1) ? rand40() : 40'($urandom_range(0, 5000)));
					budget++;
				end else
					push_item(REQ_UNUSED, rand24(), rand40());
			end
			wait_idle();
		end

		// total saturates on restore with large steps, then step count saturates
		in_calm  = 1'b0;
		out_calm = 1'b0;
		write_reg(pfm_pkg::REG_PPL, 16'hFFFF);
		write_reg(pfm_pkg::REG_LPS, 16'h00FF);
		push_item(pfm_pkg::REQ_RESTORE, rand24(), 40'h01_0000_0000);
		queue_window(4, 24'd123);
		wait_idle();
		write_reg(pfm_pkg::REG_PPL, 16'd1);
		write_reg(pfm_pkg::REG_LPS, 16'd1);
		queue_window(2, 24'd1);
		push_item(pfm_pkg::REQ_RESTORE, rand24(), 40'hFF_FFFF_FFFF);
		queue_window(1, 24'd1);
		wait_idle();

		// back to back pulses with a calm input side
		write_reg(pfm_pkg::REG_PPL, pfm_pkg::PPL_RESET);
		n_settings += 3;
		in_calm = 1'b1;
		queue_window(40, 24'($urandom_range(1, 16777215)));
		wait_idle();

		if (expected_readings.size() != 0)
			report_mismatch($sformatf("%0d readings never arrived",
				expected_readings.size()));

		$display("Summary: %0d pulses, %0d samples, %0d restores, %0d unused codes",
			n_pulses, n_samples, n_restores, n_unused);
		$display("Summary: %0d register settings, %0d readings checked, %0d mismatches",
			n_settings, readings_checked, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
